// ----- rtl/urs_pkg.sv -----
// ---------------------------------------------------------------------------
// urs_pkg: shared types and constants of the unique row sorter
// Row and result beat layouts, the cell entry, the comparator result and
// the row width mask.
// ---------------------------------------------------------------------------
package urs_pkg;

   localparam int ROW_W         = 32;
   localparam int CFG_W         = 6;
   localparam int MAX_ROW_WIDTH = 32;
   localparam int RESET_WIDTH   = 32;

   typedef struct packed {
      logic [ROW_W-1:0] row_bits;
      logic             last_row;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_value;
      logic             last_out;
      logic             empty_set;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic             repeated;
      logic [ROW_W-1:0] value;
   } cell_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_type;

   // A width of zero counts as one bit; widths above the maximum are clamped.
   function automatic logic [ROW_W-1:0] row_mask(input logic [CFG_W-1:0] width);
      logic [CFG_W-1:0] wc;
      logic [ROW_W:0]   m;
      begin
         wc = width;
         if (wc == '0) begin
            wc = CFG_W'(1);
         end
         if (wc > CFG_W'(MAX_ROW_WIDTH)) begin
            wc = CFG_W'(MAX_ROW_WIDTH);
         end
         m = ({{ROW_W{1'b0}}, 1'b1} << wc) - {{ROW_W{1'b0}}, 1'b1};
         return m[ROW_W-1:0];
      end
   endfunction

endpackage

// ----- rtl/urs_cell_mem.sv -----
// ---------------------------------------------------------------------------
// urs_cell_mem: cell store
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module urs_cell_mem #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  urs_pkg::cell_type    wr_data,
   input  logic [IDX_W-1:0]     rd_addr,
   output urs_pkg::cell_type    rd_data
);
   import urs_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/urs_cmp.sv -----
// ---------------------------------------------------------------------------
// urs_cmp: shared row comparator
// Equality and unsigned less-than of a stored cell against an operand.
// ---------------------------------------------------------------------------
module urs_cmp (
   input  logic [urs_pkg::ROW_W-1:0] cell_val,
   input  logic [urs_pkg::ROW_W-1:0] ref_val,
   output urs_pkg::cmp_type          result
);
   import urs_pkg::*;

   always_comb begin
      result.eq = (cell_val == ref_val);
      result.lt = (cell_val < ref_val);
   end

endmodule

// ----- rtl/unique_row_sorter.sv -----
// ---------------------------------------------------------------------------
// unique_row_sorter: sort a set of rows and drop every repeated value
// Rows are collected into a cell store; values seen more than once are
// dropped with all copies, and the rest leave in ascending order.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_stall  | req_type: row_bits, last_row
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_type: row_value, flags
//   csr     | in        | csr_valid/csr_ready  | row_width, 6 bits
//
// Each accepted row is checked against the cells filled so far: one comparator
// walks the cell store one read per cycle, and the next beat waits for the walk.
// The walk stops early on a copy. After the last row, each result takes a pass
// over the store and a load of the result register, which waits while that
// register is stalled. Reset is synchronous; it empties the set and sets
// row_width to 32. The next set's first row is taken while the final result
// still waits in the output register.
module unique_row_sorter #(
   parameter int MAX_ROWS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  urs_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output urs_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [urs_pkg::CFG_W-1:0]     csr_data
);
   import urs_pkg::*;

   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam int CNT_W = $clog2(MAX_ROWS + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_FIND = 4'b0010,
      S_PICK = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [ROW_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             best_vld_ff, best_vld_in;
   logic             multi_ff, multi_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   cell_type         mem_wdata;
   cell_type         mem_rdata;
   logic             issue;
   logic             drained;
   logic             done;
   logic             load;
   logic [ROW_W-1:0] cmp_ref;
   cmp_type          cmp;

   urs_cell_mem #(
      .DEPTH (MAX_ROWS),
      .IDX_W (IDX_W)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (mem_rdata)
   );

   urs_cmp u_cmp (
      .cell_val (mem_rdata.value),
      .ref_val  (cmp_ref),
      .result   (cmp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign issue   = ((state_ff == S_FIND) || (state_ff == S_PICK)) && (scan_idx_ff < count_ff);
   assign drained = !issue && !chk_vld_ff;
   assign cmp_ref = (state_ff == S_FIND) ? row_ff : best_ff;

   always_comb begin
      state_in    = state_ff;
      width_in    = width_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      row_in      = row_ff;
      last_in     = last_ff;
      scan_idx_in = scan_idx_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      best_vld_in = best_vld_ff;
      multi_in    = multi_ff;
      rsp_data_in = rsp_data_ff;
      mem_we      = 1'b0;
      mem_waddr   = chk_idx_ff;
      mem_wdata   = '0;
      done        = 1'b0;
      load        = 1'b0;

      if (csr_valid) begin
         width_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               row_in      = req_data.row_bits & row_mask(width_ff);
               last_in     = req_data.last_row;
               scan_idx_in = '0;
               state_in    = S_FIND;
            end
         end
         S_FIND: begin
            // Reads run one address ahead of the compare.
            scan_idx_in = scan_idx_ff + CNT_W'(issue);
            chk_vld_in  = issue;
            chk_idx_in  = scan_idx_ff[IDX_W-1:0];
            if (chk_vld_ff && cmp.eq) begin
               mem_we    = 1'b1;
               mem_waddr = chk_idx_ff;
               mem_wdata = '{repeated: 1'b1, value: row_ff};
               done      = 1'b1;
            end else if (drained) begin
               if (count_ff < CNT_W'(MAX_ROWS)) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[IDX_W-1:0];
                  mem_wdata = '{repeated: 1'b0, value: row_ff};
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               done = 1'b1;
            end
            if (done) begin
               chk_vld_in = 1'b0;
               if (last_ff) begin
                  scan_idx_in = '0;
                  best_vld_in = 1'b0;
                  multi_in    = 1'b0;
                  state_in    = S_PICK;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PICK: begin
            scan_idx_in = scan_idx_ff + CNT_W'(issue);
            chk_vld_in  = issue;
            chk_idx_in  = scan_idx_ff[IDX_W-1:0];
            // Emitted cells are marked repeated, so each pass finds the
            // smallest value not yet sent and whether another one follows.
            if (chk_vld_ff && !mem_rdata.repeated) begin
               if (!best_vld_ff || cmp.lt) begin
                  best_in     = mem_rdata.value;
                  best_idx_in = chk_idx_ff;
               end
               best_vld_in = 1'b1;
               if (best_vld_ff) begin
                  multi_in = 1'b1;
               end
            end
            if (drained) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load                  = 1'b1;
               rsp_data_in.row_value = best_vld_ff ? best_ff : '0;
               rsp_data_in.last_out  = !multi_ff;
               rsp_data_in.empty_set = !best_vld_ff;
               rsp_data_in.overflow  = ovf_ff;
               if (best_vld_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = best_idx_ff;
                  mem_wdata = '{repeated: 1'b1, value: best_ff};
               end
               if (multi_ff) begin
                  scan_idx_in = '0;
                  best_vld_in = 1'b0;
                  multi_in    = 1'b0;
                  state_in    = S_PICK;
               end else begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= CFG_W'(RESET_WIDTH);
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      last_ff     <= last_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      best_vld_ff <= best_vld_in;
      multi_ff    <= multi_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_accept_starts_find: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_FIND))
      else $error("accepted row did not start a cell search");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ROWS))
      else $error("cell count above capacity");

   a_empty_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.empty_set) |->
         (rsp_data_ff.last_out && (rsp_data_ff.row_value == '0)))
      else $error("empty result not final or not zero");

   a_chk_only_scanning: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> ((state_ff == S_FIND) || (state_ff == S_PICK)))
      else $error("pending cell read outside a scan");
`endif

endmodule

// ----- verif/tb_unique_row_sorter.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_unique_row_sorter: self-checking bench for the unique row sorter
// Rows are sent in sets with random gaps and result stalls. A ledger keeps
// its own copy of the cell store, works out the rows that survive each set
// and compares every result beat against them in order.
// ---------------------------------------------------------------------------
module tb_unique_row_sorter;
   import urs_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int CELLS       = 64;
   localparam int SETTLE      = CELLS + 16;
   localparam int RANDOM_ROWS = 370;
   localparam int QUIET_ROWS  = 60;
   localparam int CYCLE_LIMIT = 1000000;

   typedef enum int {FROM_POOL, FRESH, NEAR_POOL} row_source_type;

   // Keeps the cell store of the current set and the surviving rows that
   // are still owed by the block.
   class unique_rows_ledger;
      logic [CFG_W-1:0] row_width;
      logic [ROW_W-1:0] cell_val [CELLS];
      bit               cell_rep [CELLS];
      bit               cell_used[CELLS];
      bit               overflow_seen;
      rsp_type          survivors_q[$];
      int               misses;

      function new();
         row_width = CFG_W'(RESET_WIDTH);
         misses    = 0;
         clear_set();
      endfunction

      function void clear_set();
         for (int i = 0; i < CELLS; i++) begin
            cell_val[i]  = '0;
            cell_rep[i]  = 1'b0;
            cell_used[i] = 1'b0;
         end
         overflow_seen = 1'b0;
      endfunction

      function logic [ROW_W-1:0] width_mask();
         int w;
         w = row_width;
         if (w < 1) w = 1;
         if (w > MAX_ROW_WIDTH) w = MAX_ROW_WIDTH;
         if (w >= ROW_W) return '1;
         return (ROW_W'(1) << w) - ROW_W'(1);
      endfunction

      function int pending();
         return survivors_q.size();
      endfunction

      function void take_row(req_type beat);
         logic [ROW_W-1:0] v;
         logic [ROW_W-1:0] kept[$];
         rsp_type          r;
         int               free_idx;
         bit               hit;
         v        = beat.row_bits & width_mask();
         free_idx = -1;
         hit      = 1'b0;
         for (int i = 0; i < CELLS; i++) begin
            if (cell_used[i]) begin
               if (!hit && cell_val[i] == v) begin
                  cell_rep[i] = 1'b1;
                  hit         = 1'b1;
               end
            end else if (free_idx < 0) begin
               free_idx = i;
            end
         end
         if (!hit) begin
            if (free_idx < 0) begin
               overflow_seen = 1'b1;
            end else begin
               cell_used[free_idx] = 1'b1;
               cell_rep[free_idx]  = 1'b0;
               cell_val[free_idx]  = v;
            end
         end
         if (!beat.last_row) return;

         for (int i = 0; i < CELLS; i++) begin
            if (cell_used[i] && !cell_rep[i]) kept.push_back(cell_val[i]);
         end
         kept.sort();
         if (kept.size() == 0) begin
            r.row_value = '0;
            r.last_out  = 1'b1;
            r.empty_set = 1'b1;
            r.overflow  = overflow_seen;
            survivors_q.push_back(r);
         end
         for (int i = 0; i < kept.size(); i++) begin
            r.row_value = kept[i];
            r.last_out  = (i == kept.size() - 1);
            r.empty_set = 1'b0;
            r.overflow  = overflow_seen;
            survivors_q.push_back(r);
         end
         clear_set();
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (survivors_q.size() == 0) begin
            misses++;
            if (misses <= 10)
               $display("%0t: result with nothing owed: value %h last %b empty %b ovf %b",
                        $realtime, got.row_value, got.last_out, got.empty_set,
                        got.overflow);
            return;
         end
         want = survivors_q.pop_front();
         if (got.row_value !== want.row_value || got.last_out !== want.last_out ||
             got.empty_set !== want.empty_set || got.overflow !== want.overflow) begin
            misses++;
            if (misses <= 10)
               $display("%0t: mismatch: expected value %h last %b empty %b ovf %b, %s",
                        $realtime, want.row_value, want.last_out, want.empty_set,
                        want.overflow,
                        $sformatf("got value %h last %b empty %b ovf %b",
                                  got.row_value, got.last_out, got.empty_set,
                                  got.overflow));
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data;

   unique_rows_ledger ledger;
   bit                quiet = 1'b0;
   int                rows_sent = 0;
   int                cycle_count = 0;

   unique_row_sorter #(
      .MAX_ROWS (CELLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) ledger.match_result(rsp_data);
   end

   // Result side stalls in random bursts, with longer open stretches.
   initial begin : rsp_backpressure
      int span;
      bit hold;
      rsp_stall <= 1'b0;
      forever begin
         span = $urandom_range(1, 14);
         hold = !quiet && ($urandom_range(0, 2) == 0);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            hold = 1'b0;
            span = 60;
         end
         rsp_stall <= hold;
         repeat (span) @(posedge clock);
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_unique_row_sorter NOT OK");
      $finish;
   end

   task automatic send_row(input logic [ROW_W-1:0] bits, input bit is_last,
                           input bit gaps);
      req_type beat;
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      beat.row_bits = bits;
      beat.last_row = is_last;
      req_data  <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.take_row(beat);
      rows_sent++;
   endtask

   // Holds off new rows until every owed result is out and the block has
   // had time to finish its last pass over the cells.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_width(input logic [CFG_W-1:0] w);
      wait_idle();
      csr_data  <= w;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ledger.row_width = w;
   endtask

   function automatic logic [CFG_W-1:0] pick_width();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3: return CFG_W'(MAX_ROW_WIDTH);
         default: return CFG_W'($urandom_range(1, MAX_ROW_WIDTH - 1));
      endcase
   endfunction

   initial begin : stimulus
      logic [ROW_W-1:0] pool[$];
      logic [ROW_W-1:0] v;
      row_source_type   source;
      int               set_len;
      int               set_no;
      int               random_start;
      bit               gaps;

      ledger    = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Width after reset: extremes of the row field, sorted on the way out.
      send_row(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_row(32'h0000_0000, 1'b0, 1'b1);
      send_row(32'h8000_0000, 1'b0, 1'b0);
      send_row(32'h0000_0001, 1'b1, 1'b1);
      send_row(32'h5A5A_5A5A, 1'b1, 1'b0);
      // A pair of copies leaves nothing, so an empty beat is owed.
      send_row(32'h1234_5678, 1'b0, 1'b0);
      send_row(32'h1234_5678, 1'b1, 1'b0);
      send_row(32'd7, 1'b0, 1'b1);
      send_row(32'd3, 1'b0, 1'b1);
      send_row(32'd7, 1'b0, 1'b1);
      send_row(32'd9, 1'b0, 1'b1);
      send_row(32'd3, 1'b1, 1'b1);
      set_width(CFG_W'(1));
      send_row(32'hFFFF_FFFE, 1'b0, 1'b0);
      send_row(32'h0000_0003, 1'b1, 1'b0);
      // Zero width behaves as one bit, so both rows collapse to zero.
      set_width('0);
      send_row(32'h0000_0002, 1'b0, 1'b0);
      send_row(32'h0000_0004, 1'b1, 1'b0);
      set_width('1);
      send_row(32'hF000_0000, 1'b0, 1'b0);
      send_row(32'h0F00_0000, 1'b1, 1'b0);
      // Width changes inside a set; each row keeps the mask it arrived with.
      set_width(CFG_W'(4));
      send_row(32'h0000_001F, 1'b0, 1'b0);
      set_width(CFG_W'(8));
      send_row(32'h0000_001F, 1'b1, 1'b0);

      // Fill every cell, push two more new values past the capacity, then
      // repeat two stored values while the store is full.
      random_start = rows_sent;
      set_width(CFG_W'(MAX_ROW_WIDTH));
      pool.delete();
      for (int k = 0; k < CELLS + 2; k++) begin
         v = ($urandom() & 32'hFFFF_FF80) | ROW_W'(k);
         pool.push_back(v);
         send_row(v, 1'b0, 1'b1);
      end
      send_row(pool[0], 1'b0, 1'b1);
      send_row(pool[1], 1'b1, 1'b1);

      set_no = 0;
      while (rows_sent - random_start < RANDOM_ROWS) begin
         quiet = (rows_sent - random_start >= RANDOM_ROWS - QUIET_ROWS);
         case ($urandom_range(0, 19))
            0: set_len = $urandom_range(41, 70);
            1, 2, 3, 4, 5: set_len = $urandom_range(11, 40);
            default: set_len = $urandom_range(1, 10);
         endcase
         gaps = !quiet && ($urandom_range(0, 2) != 0);
         pool.delete();
         repeat ($urandom_range(1, set_len)) pool.push_back($urandom());
         source = row_source_type'($urandom_range(0, 2));
         for (int k = 0; k < set_len; k++) begin
            case (source)
               FRESH:     v = $urandom();
               NEAR_POOL: v = pool[$urandom_range(0, pool.size() - 1)] ^
                              (ROW_W'(1) << $urandom_range(0, ROW_W - 1));
               default:   v = pool[$urandom_range(0, pool.size() - 1)];
            endcase
            if (k == set_len / 2 && k > 0 && $urandom_range(0, 19) == 0)
               set_width(pick_width());
            send_row(v, k == set_len - 1, gaps);
         end
         if ($urandom_range(0, 4) == 0) wait_idle();
         if (set_no % 6 == 5) set_width(pick_width());
         set_no++;
      end

      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (ledger.misses == 0 && ledger.pending() == 0) begin
         $display("tb_unique_row_sorter OK");
      end else begin
         $display("tb_unique_row_sorter NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/urs_pkg.sv
rtl/urs_cell_mem.sv
rtl/urs_cmp.sv
rtl/unique_row_sorter.sv
verif/tb_unique_row_sorter.sv
